// ----- rtl/minmax_scale_to_hundred_core_defines.svh -----
// assertion macros for the min-max scaling block
// used by the files that carry concurrent assertions; expects clk and rst in scope
`ifndef MINMAX_SCALE_TO_HUNDRED_CORE_DEFINES_SVH
`define MINMAX_SCALE_TO_HUNDRED_CORE_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define MMSH_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition that holds in the cycle after a trigger
`define MMSH_IMPLIES_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mmsh_pkg.sv -----
// shared constants and controller/datapath command types for min-max scaling
// no dependencies
`default_nettype none

package mmsh_pkg;

  localparam int MAX_LEN_DEF     = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // result format: 0..100 with 8 fraction bits
  localparam int SCALED_W     = 15;
  localparam int FRAC_BITS    = 8;
  localparam int SCALE_FACTOR = 100;
  localparam int SCALE_W      = 7;
  localparam int SCALED_MAX   = SCALE_FACTOR << FRAC_BITS;

  // width of the divider step counter; one quotient bit per step
  localparam int STEP_W = $clog2(SCALED_W);

  typedef struct packed {
    logic load;      // input word accepted
    logic rd;        // read stored sample at replay index
    logic mul;       // form (sample - min) * 100
    logic div_init;  // load divider
    logic div_step;  // one restoring step
    logic put;       // write result into output register
    logic rd_next;   // advance replay index
    logic clear;     // end of frame, back to reset values
  } mmsh_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a word this cycle
    logic last;      // replay index points at last stored sample
  } mmsh_stat_t;

endpackage

`default_nettype wire

// ----- rtl/mmsh_if.sv -----
// valid/ready channel interfaces for sample input and scaled result output
// depends on mmsh_pkg for default widths
`default_nettype none

interface mmsh_in_if #(
  parameter int SAMPLE_BITS = mmsh_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          frame_end;

  modport source (output valid, sample, frame_end, input ready);
  modport sink (input valid, sample, frame_end, output ready);
endinterface

interface mmsh_out_if;
  logic                          valid;
  logic                          ready;
  logic [mmsh_pkg::SCALED_W-1:0] scaled;
  logic                          run_end;
  logic                          flat;
  logic                          dropped;

  modport source (output valid, scaled, run_end, flat, dropped, input ready);
  modport sink (input valid, scaled, run_end, flat, dropped, output ready);
endinterface

`default_nettype wire

// ----- rtl/mmsh_div.sv -----
// restoring divider, one quotient bit per step, for the scaled result
// depends on mmsh_pkg; dividend is prod * 2^FRAC_BITS, quotient known to fit SCALED_W bits
`default_nettype none

module mmsh_div #(
  parameter int SAMPLE_BITS = mmsh_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                             clk,
  input  wire logic                                             init,
  input  wire logic                                             step,
  input  wire logic [SAMPLE_BITS+mmsh_pkg::SCALE_W-1:0]         prod,
  input  wire logic [SAMPLE_BITS-1:0]                           den,
  output logic      [mmsh_pkg::SCALED_W-1:0]                    quo
);
  import mmsh_pkg::*;

  localparam int SHIFT_W = SCALED_W - FRAC_BITS;

  logic [SAMPLE_BITS-1:0] rem;
  logic [SCALED_W-1:0]    low;
  logic [SAMPLE_BITS:0]   shifted;
  logic [SAMPLE_BITS+1:0] trial;

  // partial remainder with next dividend bit, trial subtract
  assign shifted = {rem, low[SCALED_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den};

  // remainder starts below den since the quotient fits SCALED_W bits
  always_ff @(posedge clk) begin
    if (init) begin
      rem <= prod[SAMPLE_BITS+SCALE_W-1:SHIFT_W];
      low <= {prod[SHIFT_W-1:0], {FRAC_BITS{1'b0}}};
      quo <= '0;
    end else if (step) begin
      low <= {low[SCALED_W-2:0], 1'b0};
      if (!trial[SAMPLE_BITS+1]) begin
        rem <= trial[SAMPLE_BITS-1:0];
        quo <= {quo[SCALED_W-2:0], 1'b1};
      end else begin
        rem <= shifted[SAMPLE_BITS-1:0];
        quo <= {quo[SCALED_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mmsh_ctrl.sv -----
// controller for min-max scaling: load phase, then per-sample replay sequence
// depends on mmsh_pkg command and status types
`default_nettype none

module mmsh_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  output logic                      in_ready,
  input  wire mmsh_pkg::mmsh_stat_t stat,
  output mmsh_pkg::mmsh_cmd_t       cmd
);
  import mmsh_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_READ,
    S_MUL,
    S_DIVI,
    S_DIV,
    S_PUT
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step_cnt;

  // state register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      step_cnt <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_valid && in_last) state <= S_READ;
        end
        S_READ: state <= S_MUL;
        S_MUL:  state <= S_DIVI;
        S_DIVI: begin
          state    <= S_DIV;
          step_cnt <= '0;
        end
        S_DIV: begin
          step_cnt <= step_cnt + STEP_W'(1);
          if (step_cnt == STEP_W'(SCALED_W - 1)) state <= S_PUT;
        end
        S_PUT: begin
          if (stat.out_free) state <= stat.last ? S_LOAD : S_READ;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd          = '0;
    in_ready     = (state == S_LOAD);
    cmd.load     = (state == S_LOAD) && in_valid;
    cmd.rd       = (state == S_READ);
    cmd.mul      = (state == S_MUL);
    cmd.div_init = (state == S_DIVI);
    cmd.div_step = (state == S_DIV);
    cmd.put      = (state == S_PUT) && stat.out_free;
    cmd.rd_next  = cmd.put && !stat.last;
    cmd.clear    = cmd.put && stat.last;
  end

endmodule

`default_nettype wire

// ----- rtl/mmsh_datapath.sv -----
// datapath for min-max scaling: sample memory, running min/max, multiply, divide, output register
// depends on mmsh_pkg, mmsh_div and the assertion macro header
`default_nettype none
`include "minmax_scale_to_hundred_core_defines.svh"

module mmsh_datapath #(
  parameter int MAX_LEN     = mmsh_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_BITS = mmsh_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mmsh_pkg::mmsh_cmd_t           cmd,
  output mmsh_pkg::mmsh_stat_t               stat,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mmsh_pkg::SCALED_W-1:0]      scaled,
  output logic                               run_end,
  output logic                               flat,
  output logic                               dropped
);
  import mmsh_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int PROD_W = SAMPLE_BITS + SCALE_W;

  localparam logic signed [SAMPLE_BITS-1:0] MIN_INIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MAX_INIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SAMPLE_BITS-1:0]        mem [MAX_LEN];
  logic [CNT_W-1:0]              fill_count;
  logic [IDX_W-1:0]              rd_idx;
  logic signed [SAMPLE_BITS-1:0] running_min;
  logic signed [SAMPLE_BITS-1:0] running_max;
  logic                          overflowed;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic [PROD_W-1:0]             prod;
  logic                          force_zero;
  logic [SCALED_W-1:0]           quo;
  logic                          full;
  logic                          is_flat;
  logic [SAMPLE_BITS:0]          diff;
  logic [SAMPLE_BITS-1:0]        range;

  assign full    = (fill_count == CNT_W'(MAX_LEN));
  assign is_flat = (running_max == running_min);
  assign diff    = {rd_data[SAMPLE_BITS-1], rd_data} - {running_min[SAMPLE_BITS-1], running_min};
  assign range   = running_max - running_min;

  assign stat.out_free = !out_valid || out_ready;
  assign stat.last     = (CNT_W'(rd_idx) == fill_count - CNT_W'(1));

  // sample memory
  always_ff @(posedge clk) begin
    if (cmd.load && !full) mem[fill_count[IDX_W-1:0]] <= sample;
    if (cmd.rd) rd_data <= mem[rd_idx];
  end

  // frame state: count, running extremes, overflow
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill_count  <= '0;
      running_min <= MIN_INIT;
      running_max <= MAX_INIT;
      overflowed  <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        overflowed <= 1'b1;
      end else begin
        fill_count <= fill_count + CNT_W'(1);
        if (sample < running_min) running_min <= sample;
        if (sample > running_max) running_max <= sample;
      end
    end
  end

  // replay index
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  // offset from minimum times 100; negative samples and flat frames give zero
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod       <= PROD_W'(diff[SAMPLE_BITS-1:0]) * PROD_W'(SCALE_FACTOR);
      force_zero <= is_flat || rd_data[SAMPLE_BITS-1];
    end
  end

  mmsh_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk (clk),
    .init(cmd.div_init),
    .step(cmd.div_step),
    .prod(prod),
    .den (range),
    .quo (quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      scaled  <= force_zero ? '0 : quo;
      run_end <= stat.last;
      flat    <= is_flat;
      dropped <= overflowed;
    end
  end

  // checks
  `MMSH_HOLDS(a_count_bound, fill_count <= CNT_W'(MAX_LEN), "fill count beyond capacity")
  `MMSH_IMPLIES_NEXT(a_clear_frame, cmd.clear, fill_count == '0 && !overflowed, "frame not cleared")
  `MMSH_HOLDS(a_scaled_range, !out_valid || scaled <= SCALED_W'(SCALED_MAX), "scaled out of range")
  `MMSH_HOLDS(a_flat_zero, !(out_valid && flat) || scaled == '0, "flat frame gave nonzero result")

endmodule

`default_nettype wire

// ----- rtl/minmax_scale_to_hundred_core.sv -----
// Min-max scaling of one spectrum to 0..100 with 8 fraction bits.
// Input channel "samples": one signed sample per word, frame_end on the final
// word of a spectrum. Words load one per cycle into a MAX_LEN-entry memory
// while a running minimum and maximum are kept; words beyond capacity are
// discarded and set the dropped flag of that frame.
// After the frame_end word the block replays every stored sample on channel
// "results": negative samples give 0, others (s - min) * 25600 / (max - min),
// truncated; flat frames give 0 with flat set; run_end marks the last result.
// After the frame_end word, each result passes through a memory read, a
// multiply, a divider load, 15 divider steps and the output write, one
// sample at a time, paced by the shared one-bit-per-step divider.
// The input is not ready during the replay; it is ready again in the cycle
// after the last result enters the output register.
// A stalled receiver holds the result in the output register and the replay
// waits until it is taken. Synchronous reset clears the frame and empties
// the output register; no clearing pass is needed.
// depends on mmsh_pkg, mmsh_if, mmsh_ctrl, mmsh_datapath
`default_nettype none

module minmax_scale_to_hundred_core #(
  parameter int MAX_LEN     = mmsh_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_BITS = mmsh_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mmsh_in_if.sink    samples,
  mmsh_out_if.source results
);
  import mmsh_pkg::*;

  mmsh_cmd_t  cmd;
  mmsh_stat_t stat;

  mmsh_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(samples.valid),
    .in_last (samples.frame_end),
    .in_ready(samples.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  mmsh_datapath #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .sample   (samples.sample),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .scaled   (results.scaled),
    .run_end  (results.run_end),
    .flat     (results.flat),
    .dropped  (results.dropped)
  );

endmodule

`default_nettype wire
